// ----- hdl/tft_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tangent frame transform package
// Shared widths and pipeline depths for the tangent frame transform.
// ----------------------------------------------------------------------------
package tft_pkg;

    localparam int DATA_W        = 16;
    localparam int FRAC_BITS_DEF = 14;

    // Squared component (at most 2^30), sum of two squares (at most 2^31),
    // and the unit component magnitude (at most 2^15).
    localparam int SQ_W   = 2 * DATA_W - 1;
    localparam int SUM_W  = 2 * DATA_W;
    localparam int ROOT_W = DATA_W;

    // One quotient bit per divider stage, one root bit per square root stage.
    localparam int DIV_STEPS  = SQ_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int UNIT_LAT   = DIV_STEPS + SQRT_STEPS;

endpackage

// ----- hdl/tangent_frame_transform.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tangent frame transform
// Rotates a local direction into world space through a frame built from a
// surface normal, with a normalized tangent, rounding and saturation.
// ----------------------------------------------------------------------------
// The result path runs through the 31-stage divider and 16-stage square root.
// Throughput: one transaction per cycle while the output slot is empty; a
// one-entry skid slot keeps the input ready free of a combinational path from
// the output ready, and a held slot stalls the whole pipeline until it drains.
// Reset clears all valid bits, the output slot's included; data is not reset.
module tangent_frame_transform
#(
    parameter int FRAC_BITS = tft_pkg::FRAC_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [tft_pkg::DATA_W-1:0] local_x,
    input  logic signed [tft_pkg::DATA_W-1:0] local_y,
    input  logic signed [tft_pkg::DATA_W-1:0] local_z,
    input  logic signed [tft_pkg::DATA_W-1:0] normal_x,
    input  logic signed [tft_pkg::DATA_W-1:0] normal_y,
    input  logic signed [tft_pkg::DATA_W-1:0] normal_z,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [tft_pkg::DATA_W-1:0] world_x,
    output logic signed [tft_pkg::DATA_W-1:0] world_y,
    output logic signed [tft_pkg::DATA_W-1:0] world_z,
    output logic                              degenerate
);

    localparam int DW    = tft_pkg::DATA_W;
    localparam int SQ_W  = tft_pkg::SQ_W;
    localparam int SUM_W = tft_pkg::SUM_W;
    localparam int RW    = tft_pkg::ROOT_W;
    localparam int LAT   = tft_pkg::UNIT_LAT;
    localparam int CW    = DW + 1;            // unit component, Q1.15 with sign
    localparam int PW    = DW + CW;           // normal times component
    localparam int BW    = PW + 1;            // bitangent component
    localparam int XBW   = DW + BW;
    localparam int YCW   = DW + CW;
    localparam int ZNW   = 2 * DW;
    localparam int SH    = FRAC_BITS + 15;
    localparam int ACC_W = ((YCW + FRAC_BITS > XBW) ? (YCW + FRAC_BITS) : XBW) + 2;

    localparam logic signed [ACC_W-1:0] RND     = ACC_W'(1) << (SH - 1);
    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

    typedef struct packed {
        logic [DW-1:0] x;
        logic [DW-1:0] y;
        logic [DW-1:0] z;
        logic [DW-1:0] nx;
        logic [DW-1:0] ny;
        logic [DW-1:0] nz;
        logic          sel;
        logic          sign_a;
        logic          sign_b;
        logic          degen;
    } side_t;

    logic en;

    logic r0_valid_reg, r1_valid_reg, r2_valid_reg;
    logic [LAT-1:0] dly_valid_reg;
    logic r3_valid_reg, r4_valid_reg, r5_valid_reg;
    logic r6_valid_reg, r7_valid_reg, r8_valid_reg;

    logic signed [DW-1:0] r0_x_reg, r0_y_reg, r0_z_reg;
    logic signed [DW-1:0] r0_nx_reg, r0_ny_reg, r0_nz_reg;

    side_t          r1_side_next, r1_side_reg;
    logic [SQ_W-1:0] r1_sq_a_next, r1_sq_b_next, r1_sq_a_reg, r1_sq_b_reg;

    side_t           r2_side_reg;
    logic [SQ_W-1:0]  r2_sq_a_reg, r2_sq_b_reg;
    logic [SUM_W-1:0] r2_s_reg;

    side_t dly_side_reg [0:LAT-1];
    logic [RW-1:0] root_a, root_b;

    side_t r3_side_reg;
    logic signed [CW-1:0] r3_cx_next, r3_cy_next, r3_cz_next;
    logic signed [CW-1:0] r3_cx_reg, r3_cy_reg, r3_cz_reg;

    side_t r4_side_reg;
    logic signed [CW-1:0] r4_cx_reg, r4_cy_reg, r4_cz_reg;
    logic signed [PW-1:0] r4_ny_cz_reg, r4_nz_cy_reg, r4_nz_cx_reg;
    logic signed [PW-1:0] r4_nx_cz_reg, r4_nx_cy_reg, r4_ny_cx_reg;

    side_t r5_side_reg;
    logic signed [CW-1:0] r5_cx_reg, r5_cy_reg, r5_cz_reg;
    logic signed [BW-1:0] r5_bx_reg, r5_by_reg, r5_bz_reg;

    logic                  r6_degen_reg;
    logic signed [XBW-1:0] r6_xb_reg [0:2];
    logic signed [YCW-1:0] r6_yc_reg [0:2];
    logic signed [ZNW-1:0] r6_zn_reg [0:2];

    logic                    r7_degen_reg;
    logic signed [ACC_W-1:0] r7_acc_next [0:2];
    logic signed [ACC_W-1:0] r7_acc_reg  [0:2];

    logic                 r8_degen_reg;
    logic signed [DW-1:0] r8_world_next [0:2];
    logic signed [DW-1:0] r8_world_reg  [0:2];

    logic                 skid_valid_reg;
    logic                 skid_degen_reg;
    logic signed [DW-1:0] skid_world_reg [0:2];

    // The whole pipeline moves whenever the output stage has a free slot.
    assign en       = ~skid_valid_reg;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r0_valid_reg  <= 1'b0;
            r1_valid_reg  <= 1'b0;
            r2_valid_reg  <= 1'b0;
            dly_valid_reg <= '0;
            r3_valid_reg  <= 1'b0;
            r4_valid_reg  <= 1'b0;
            r5_valid_reg  <= 1'b0;
            r6_valid_reg  <= 1'b0;
            r7_valid_reg  <= 1'b0;
            r8_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            r0_valid_reg  <= in_valid;
            r1_valid_reg  <= r0_valid_reg;
            r2_valid_reg  <= r1_valid_reg;
            dly_valid_reg <= {dly_valid_reg[LAT-2:0], r2_valid_reg};
            r3_valid_reg  <= dly_valid_reg[LAT-1];
            r4_valid_reg  <= r3_valid_reg;
            r5_valid_reg  <= r4_valid_reg;
            r6_valid_reg  <= r5_valid_reg;
            r7_valid_reg  <= r6_valid_reg;
            r8_valid_reg  <= r7_valid_reg;
        end
    end

    // Tangent choice and the squares of both raw tangent components.
    always_comb
    begin
        logic signed [DW:0]     ax;
        logic signed [DW:0]     ay;
        logic signed [DW-1:0]   u;
        logic signed [2*DW-1:0] sq_a_full;
        logic signed [2*DW-1:0] sq_b_full;
        ax = $signed({r0_nx_reg[DW-1], r0_nx_reg});
        ay = $signed({r0_ny_reg[DW-1], r0_ny_reg});
        if (ax < 0)
        begin
            ax = -ax;
        end
        if (ay < 0)
        begin
            ay = -ay;
        end
        r1_side_next.sel = ax > ay;
        u = r1_side_next.sel ? r0_nx_reg : r0_ny_reg;
        sq_a_full = (2*DW)'(r0_nz_reg) * (2*DW)'(r0_nz_reg);
        sq_b_full = (2*DW)'(u) * (2*DW)'(u);
        r1_sq_a_next = sq_a_full[SQ_W-1:0];
        r1_sq_b_next = sq_b_full[SQ_W-1:0];
        r1_side_next.x      = r0_x_reg;
        r1_side_next.y      = r0_y_reg;
        r1_side_next.z      = r0_z_reg;
        r1_side_next.nx     = r0_nx_reg;
        r1_side_next.ny     = r0_ny_reg;
        r1_side_next.nz     = r0_nz_reg;
        r1_side_next.sign_a = r0_nz_reg[DW-1];
        // The second raw component is the negated selected normal component.
        r1_side_next.sign_b = ~u[DW-1] && (u != '0);
        r1_side_next.degen  = (r0_nx_reg == '0) && (r0_ny_reg == '0) && (r0_nz_reg == '0);
    end

    // Signed unit tangent placed by the tangent choice.
    always_comb
    begin
        logic signed [CW-1:0] ca;
        logic signed [CW-1:0] cb;
        ca = $signed({1'b0, root_a});
        cb = $signed({1'b0, root_b});
        if (dly_side_reg[LAT-1].sign_a)
        begin
            ca = -ca;
        end
        if (dly_side_reg[LAT-1].sign_b)
        begin
            cb = -cb;
        end
        r3_cx_next = dly_side_reg[LAT-1].sel ? ca : '0;
        r3_cy_next = dly_side_reg[LAT-1].sel ? '0 : ca;
        r3_cz_next = cb;
    end

    // Weighted sum with the round-half-up constant folded in.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            r7_acc_next[i] = ACC_W'(r6_xb_reg[i])
                           + (ACC_W'(r6_yc_reg[i]) <<< FRAC_BITS)
                           + (ACC_W'(r6_zn_reg[i]) <<< 15)
                           + RND;
        end
    end

    always_comb
    begin
        logic signed [ACC_W-1:0] q;
        for (int i = 0; i < 3; i++)
        begin
            q = r7_acc_reg[i] >>> SH;
            if (r7_degen_reg)
            begin
                r8_world_next[i] = '0;
            end
            else if (q > SAT_MAX)
            begin
                r8_world_next[i] = SAT_MAX[DW-1:0];
            end
            else if (q < SAT_MIN)
            begin
                r8_world_next[i] = SAT_MIN[DW-1:0];
            end
            else
            begin
                r8_world_next[i] = q[DW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r0_x_reg  <= local_x;
            r0_y_reg  <= local_y;
            r0_z_reg  <= local_z;
            r0_nx_reg <= normal_x;
            r0_ny_reg <= normal_y;
            r0_nz_reg <= normal_z;

            r1_side_reg <= r1_side_next;
            r1_sq_a_reg <= r1_sq_a_next;
            r1_sq_b_reg <= r1_sq_b_next;

            r2_side_reg <= r1_side_reg;
            r2_sq_a_reg <= r1_sq_a_reg;
            r2_sq_b_reg <= r1_sq_b_reg;
            r2_s_reg    <= SUM_W'(r1_sq_a_reg) + SUM_W'(r1_sq_b_reg);

            dly_side_reg[0] <= r2_side_reg;
            for (int i = 1; i < LAT; i++)
            begin
                dly_side_reg[i] <= dly_side_reg[i-1];
            end

            r3_side_reg <= dly_side_reg[LAT-1];
            r3_cx_reg   <= r3_cx_next;
            r3_cy_reg   <= r3_cy_next;
            r3_cz_reg   <= r3_cz_next;

            r4_side_reg  <= r3_side_reg;
            r4_cx_reg    <= r3_cx_reg;
            r4_cy_reg    <= r3_cy_reg;
            r4_cz_reg    <= r3_cz_reg;
            r4_ny_cz_reg <= PW'($signed(r3_side_reg.ny)) * PW'(r3_cz_reg);
            r4_nz_cy_reg <= PW'($signed(r3_side_reg.nz)) * PW'(r3_cy_reg);
            r4_nz_cx_reg <= PW'($signed(r3_side_reg.nz)) * PW'(r3_cx_reg);
            r4_nx_cz_reg <= PW'($signed(r3_side_reg.nx)) * PW'(r3_cz_reg);
            r4_nx_cy_reg <= PW'($signed(r3_side_reg.nx)) * PW'(r3_cy_reg);
            r4_ny_cx_reg <= PW'($signed(r3_side_reg.ny)) * PW'(r3_cx_reg);

            r5_side_reg <= r4_side_reg;
            r5_cx_reg   <= r4_cx_reg;
            r5_cy_reg   <= r4_cy_reg;
            r5_cz_reg   <= r4_cz_reg;
            r5_bx_reg   <= BW'(r4_ny_cz_reg) - BW'(r4_nz_cy_reg);
            r5_by_reg   <= BW'(r4_nz_cx_reg) - BW'(r4_nx_cz_reg);
            r5_bz_reg   <= BW'(r4_nx_cy_reg) - BW'(r4_ny_cx_reg);

            r6_degen_reg <= r5_side_reg.degen;
            r6_xb_reg[0] <= XBW'($signed(r5_side_reg.x)) * XBW'(r5_bx_reg);
            r6_xb_reg[1] <= XBW'($signed(r5_side_reg.x)) * XBW'(r5_by_reg);
            r6_xb_reg[2] <= XBW'($signed(r5_side_reg.x)) * XBW'(r5_bz_reg);
            r6_yc_reg[0] <= YCW'($signed(r5_side_reg.y)) * YCW'(r5_cx_reg);
            r6_yc_reg[1] <= YCW'($signed(r5_side_reg.y)) * YCW'(r5_cy_reg);
            r6_yc_reg[2] <= YCW'($signed(r5_side_reg.y)) * YCW'(r5_cz_reg);
            r6_zn_reg[0] <= ZNW'($signed(r5_side_reg.z)) * ZNW'($signed(r5_side_reg.nx));
            r6_zn_reg[1] <= ZNW'($signed(r5_side_reg.z)) * ZNW'($signed(r5_side_reg.ny));
            r6_zn_reg[2] <= ZNW'($signed(r5_side_reg.z)) * ZNW'($signed(r5_side_reg.nz));

            r7_degen_reg <= r6_degen_reg;
            r8_degen_reg <= r7_degen_reg;
            for (int i = 0; i < 3; i++)
            begin
                r7_acc_reg[i]   <= r7_acc_next[i];
                r8_world_reg[i] <= r8_world_next[i];
            end
        end
    end

    tft_unit_comp u_comp_a
    (
        .clk  (clk),
        .en   (en),
        .sq   (r2_sq_a_reg),
        .s    (r2_s_reg),
        .root (root_a)
    );

    tft_unit_comp u_comp_b
    (
        .clk  (clk),
        .en   (en),
        .sq   (r2_sq_b_reg),
        .s    (r2_s_reg),
        .root (root_b)
    );

    // Output slot: holds the last result when the consumer stalls, which
    // frees the pipeline to advance once more.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_ready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (r8_valid_reg && !out_ready)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg)
        begin
            skid_degen_reg <= r8_degen_reg;
            for (int i = 0; i < 3; i++)
            begin
                skid_world_reg[i] <= r8_world_reg[i];
            end
        end
    end

    assign out_valid  = skid_valid_reg | r8_valid_reg;
    assign world_x    = skid_valid_reg ? skid_world_reg[0] : r8_world_reg[0];
    assign world_y    = skid_valid_reg ? skid_world_reg[1] : r8_world_reg[1];
    assign world_z    = skid_valid_reg ? skid_world_reg[2] : r8_world_reg[2];
    assign degenerate = skid_valid_reg ? skid_degen_reg : r8_degen_reg;

endmodule

// ----- hdl/tft_unit_comp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Unit component pipeline
// Computes floor(sqrt(floor(sq * 2^30 / s))) with a restoring divider of one
// quotient bit per stage followed by a square root of one bit per stage.
// ----------------------------------------------------------------------------
module tft_unit_comp
(
    input  logic                        clk,
    input  logic                        en,
    input  logic [tft_pkg::SQ_W-1:0]    sq,
    input  logic [tft_pkg::SUM_W-1:0]   s,
    output logic [tft_pkg::ROOT_W-1:0]  root
);

    localparam int SQ_W   = tft_pkg::SQ_W;
    localparam int SUM_W  = tft_pkg::SUM_W;
    localparam int ROOT_W = tft_pkg::ROOT_W;
    localparam int DSTEPS = tft_pkg::DIV_STEPS;
    localparam int RSTEPS = tft_pkg::SQRT_STEPS;

    logic [SUM_W-1:0]  div_rem_reg   [0:DSTEPS-1];
    logic [SUM_W-1:0]  div_rem_next  [0:DSTEPS-1];
    logic [SUM_W-1:0]  div_s_reg     [0:DSTEPS-1];
    logic [SUM_W-1:0]  div_s_next    [0:DSTEPS-1];
    logic [SQ_W-1:0]   div_quo_reg   [0:DSTEPS-1];
    logic [SQ_W-1:0]   div_quo_next  [0:DSTEPS-1];
    logic [SQ_W-1:0]   sqrt_rem_reg  [0:RSTEPS-1];
    logic [SQ_W-1:0]   sqrt_rem_next [0:RSTEPS-1];
    logic [ROOT_W-1:0] sqrt_root_reg [0:RSTEPS-1];
    logic [ROOT_W-1:0] sqrt_root_next[0:RSTEPS-1];

    // Divider: the first stage compares sq itself with s, since sq <= s
    // the quotient fits in SQ_W bits and every later stage shifts in a zero.
    always_comb
    begin
        logic [SUM_W:0]   trial;
        logic [SUM_W:0]   diff;
        logic [SUM_W-1:0] divisor;
        logic [SQ_W-1:0]  quo_in;
        logic             ge;
        for (int i = 0; i < DSTEPS; i++)
        begin
            if (i == 0)
            begin
                trial   = {2'b00, sq};
                divisor = s;
                quo_in  = '0;
            end
            else
            begin
                trial   = {div_rem_reg[i-1], 1'b0};
                divisor = div_s_reg[i-1];
                quo_in  = div_quo_reg[i-1];
            end
            ge              = trial >= {1'b0, divisor};
            diff            = trial - {1'b0, divisor};
            div_rem_next[i] = ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
            div_s_next[i]   = divisor;
            div_quo_next[i] = {quo_in[SQ_W-2:0], ge};
        end
    end

    // Square root: the remainder holds q - R^2 for the partial root R.
    always_comb
    begin
        logic [SQ_W-1:0]   rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [SUM_W:0]    strial;
        logic [SUM_W:0]    sdiff;
        logic              sge;
        int                k;
        for (int j = 0; j < RSTEPS; j++)
        begin
            k = RSTEPS - 1 - j;
            if (j == 0)
            begin
                rem_in  = div_quo_reg[DSTEPS-1];
                root_in = '0;
            end
            else
            begin
                rem_in  = sqrt_rem_reg[j-1];
                root_in = sqrt_root_reg[j-1];
            end
            strial = ((SUM_W+1)'(root_in) << (k + 1)) + ((SUM_W+1)'(1) << (2 * k));
            sge    = (SUM_W+1)'(rem_in) >= strial;
            sdiff  = (SUM_W+1)'(rem_in) - strial;
            sqrt_rem_next[j]  = sge ? sdiff[SQ_W-1:0] : rem_in;
            sqrt_root_next[j] = sge ? (root_in | (ROOT_W'(1) << k)) : root_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < DSTEPS; i++)
            begin
                div_rem_reg[i] <= div_rem_next[i];
                div_s_reg[i]   <= div_s_next[i];
                div_quo_reg[i] <= div_quo_next[i];
            end
            for (int j = 0; j < RSTEPS; j++)
            begin
                sqrt_rem_reg[j]  <= sqrt_rem_next[j];
                sqrt_root_reg[j] <= sqrt_root_next[j];
            end
        end
    end

    assign root = sqrt_root_reg[RSTEPS-1];

endmodule
